// ===== sv/lqlcr_pkg.sv =====
// shared types, constants and helpers for the line query longest common run unit
// no dependencies; every other file of the block imports this package
package lqlcr_pkg;

  // payload widths
  localparam int DATA_W  = 8;
  localparam int IDX_W   = 7;
  localparam int LINE_W  = 16;
  localparam int BYTES_W = 10;
  localparam int RUN_W   = 8;
  localparam int LEN_W   = 8;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // defaults for the top level parameters
  localparam int MAX_QUERY_DEF  = 128;
  localparam int LINE_LIMIT_DEF = 1000;

  // fixed codes and values
  localparam logic [DATA_W-1:0]  NEWLINE    = 8'd10;
  localparam logic [BYTES_W-1:0] BYTE_CAP   = '1;
  localparam logic [LINE_W-1:0]  LINE_CAP   = '1;
  localparam logic [LEN_W-1:0]   QLEN_RESET = 8'd1;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEXT = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_QUERY_LENGTH = 1'b0;

  // controller states
  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } lqlcr_state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              text_en;
    logic              load_en;
    logic              clear;
    logic [IDX_W-1:0]  load_idx;
    logic [DATA_W-1:0] folded;
    logic              nonzero;
    logic [LEN_W-1:0]  len;
  } cell_ctrl_t;

  // ascii upper case to lower case
  function automatic logic [DATA_W-1:0] fold_case(input logic [DATA_W-1:0] c);
    logic [DATA_W-1:0] r;
    r = c;
    if (c >= 8'd65 && c <= 8'd90) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

// ===== sv/lqlcr_if.sv =====
// valid/ready channel interfaces for request and result transactions
// depends on lqlcr_pkg for payload widths
interface lqlcr_in_if import lqlcr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [IDX_W-1:0]  query_index;
  logic [DATA_W-1:0] byte_value;

  modport source (output valid, output req_type, output query_index,
                  output byte_value, input ready);
  modport sink (input valid, input req_type, input query_index,
                input byte_value, output ready);
endinterface

interface lqlcr_out_if import lqlcr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LINE_W-1:0]  line_number;
  logic [BYTES_W-1:0] byte_count;
  logic [RUN_W-1:0]   best_match;
  logic               too_long;

  modport source (output valid, output line_number, output byte_count,
                  output best_match, output too_long, input ready);
  modport sink (input valid, input line_number, input byte_count,
                input best_match, input too_long, output ready);
endinterface

// ===== sv/lqlcr_cell.sv =====
// one query position: stored character, run length, line best and max chain stage
// depends on lqlcr_pkg
module lqlcr_cell import lqlcr_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  logic [RUN_W-1:0] run_in,
  input  logic [RUN_W-1:0] max_in,
  output logic [RUN_W-1:0] run_out,
  output logic [RUN_W-1:0] max_out
);

  logic [DATA_W-1:0] qchar;
  logic [RUN_W-1:0]  run;
  logic [RUN_W-1:0]  best;
  logic [RUN_W-1:0]  mx;
  logic [RUN_W-1:0]  run_next;
  logic              active;
  logic              match;
  logic              hit;

  // position in use and character compare
  assign active   = LEN_W'(CELL_IDX) < ctrl.len;
  assign match    = ctrl.text_en && active && ctrl.nonzero && (qchar == ctrl.folded);
  assign run_next = match ? run_in + RUN_W'(1) : '0;
  assign hit      = ctrl.load_en && ({1'b0, ctrl.load_idx} == LEN_W'(CELL_IDX));

  // query character, stored already folded
  always_ff @(posedge clk) begin
    if (hit) begin
      qchar <= ctrl.folded;
    end
  end

  // run, line best and max chain
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      run  <= '0;
      best <= '0;
      mx   <= '0;
    end else begin
      if (ctrl.text_en) begin
        run <= run_next;
        if (run_next > best) begin
          best <= run_next;
        end
      end
      mx <= (max_in > best) ? max_in : best;
    end
  end

  assign run_out = run;
  assign max_out = mx;

  // a run never exceeds the number of positions up to this one
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run <= RUN_W'(CELL_IDX + 1))
    else $error("run longer than cell position allows");

  // line best covers the current run
  a_best_covers: assert property (@(posedge clk) disable iff (rst)
    best >= run)
    else $error("line best below current run");

  // end of line empties the cell
  a_clear: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> (run == '0 && best == '0 && mx == '0))
    else $error("cell not cleared at end of line");

endmodule

// ===== sv/lqlcr_ctrl.sv =====
// controller: request decode, line counters, drain sequencing, result register, config
// depends on lqlcr_pkg and the channel interfaces in lqlcr_if
module lqlcr_ctrl import lqlcr_pkg::*; #(
  parameter int MAX_QUERY  = MAX_QUERY_DEF,
  parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  lqlcr_in_if.sink          in_ch,
  lqlcr_out_if.source       out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic [RUN_W-1:0]  best_in,
  output cell_ctrl_t        cell_ctrl
);

  localparam int CNT_W = $clog2(MAX_QUERY + 1);
  localparam logic [CNT_W-1:0] DRAIN_LEN = CNT_W'(MAX_QUERY);

  lqlcr_state_t       state;
  lqlcr_state_t       state_next;
  logic [CNT_W-1:0]   cnt;
  logic [BYTES_W-1:0] line_bytes;
  logic [BYTES_W-1:0] line_bytes_next;
  logic               overlong;
  logic [LINE_W-1:0]  line_counter;
  logic [LINE_W-1:0]  line_counter_next;
  logic [LEN_W-1:0]   query_length;
  logic [LEN_W-1:0]   len_used;
  logic               in_ready;
  logic               drain_done;
  logic               in_fire;
  logic               is_text;
  logic               is_nl;

  // request decode
  assign in_fire = in_ch.valid && in_ready;
  assign is_text = in_ch.req_type == REQ_TEXT;
  assign is_nl   = in_ch.byte_value == NEWLINE;
  assign in_ch.ready = in_ready;

  // saturating counters
  assign line_bytes_next   = (line_bytes != BYTE_CAP) ? line_bytes + BYTES_W'(1) : line_bytes;
  assign line_counter_next = (line_counter != LINE_CAP) ? line_counter + LINE_W'(1)
                                                        : line_counter;

  // positions in use
  assign len_used = (query_length > LEN_W'(MAX_QUERY)) ? LEN_W'(MAX_QUERY) : query_length;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (in_fire && is_text && is_nl && line_bytes != '0) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    drain_done = 1'b0;
    unique case (state)
      ST_RUN: begin
        in_ready = 1'b1;
      end
      ST_DRAIN: begin
        drain_done = (cnt == DRAIN_LEN) && (!out_ch.valid || out_ch.ready);
      end
      default: begin
        in_ready   = 1'b0;
        drain_done = 1'b0;
      end
    endcase
  end

  // broadcast to the cell row
  always_comb begin
    cell_ctrl.text_en  = in_fire && is_text && !is_nl;
    cell_ctrl.load_en  = in_fire && !is_text;
    cell_ctrl.clear    = drain_done;
    cell_ctrl.load_idx = in_ch.query_index;
    cell_ctrl.folded   = fold_case(in_ch.byte_value);
    cell_ctrl.nonzero  = in_ch.byte_value != '0;
    cell_ctrl.len      = len_used;
  end

  // state register and drain counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_RUN) begin
        cnt <= '0;
      end else if (cnt != DRAIN_LEN) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // line bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes   <= '0;
      overlong     <= 1'b0;
      line_counter <= LINE_W'(1);
    end else if (drain_done) begin
      line_bytes   <= '0;
      overlong     <= 1'b0;
      line_counter <= line_counter_next;
    end else if (in_fire && is_text) begin
      if (is_nl) begin
        if (line_bytes == '0) begin
          line_counter <= line_counter_next;
        end
      end else begin
        line_bytes <= line_bytes_next;
        if (line_bytes_next >= BYTES_W'(LINE_LIMIT)) begin
          overlong <= 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (drain_done) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_done) begin
      out_ch.line_number <= line_counter;
      out_ch.byte_count  <= line_bytes;
      out_ch.best_match  <= best_in;
      out_ch.too_long    <= overlong;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      query_length <= QLEN_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_QUERY_LENGTH) begin
      query_length <= pwdata[LEN_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_QUERY_LENGTH) ? {{(APB_DW-LEN_W){1'b0}}, query_length}
                                                 : '0;

  // a drain starts only for a line that holds bytes
  a_drain_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && state_next == ST_DRAIN) |=> (cnt == '0 && line_bytes != '0))
    else $error("drain started on empty line");

  // end of drain posts the result and resets the line
  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    drain_done |=> (out_ch.valid && line_bytes == '0 && !overlong))
    else $error("line not closed after drain");

  // overlong flag only with enough bytes
  a_overlong: assert property (@(posedge clk) disable iff (rst)
    overlong |-> line_bytes >= BYTES_W'(LINE_LIMIT))
    else $error("overlong flag without enough bytes");

endmodule

// ===== sv/line_query_longest_common_run_unit.sv =====
// top level: controller plus a row of query cells chained by run and max links
// depends on lqlcr_pkg, lqlcr_if, lqlcr_cell and lqlcr_ctrl
//
//  port     dir   carries
//  in_ch    sink  query load or text byte transaction (req_type, query_index, byte_value)
//  out_ch   src   line result transaction (line_number, byte_count, best_match, too_long)
//  apb      in    query_length register at byte address 0
//
//  text bytes and query loads are taken one per cycle, back to back, while no drain runs
//  a newline ending a non-empty line: the line best ripples down the cell max chain one
//  cell per cycle, the result is registered at drain end and the next transaction is
//  taken once the controller is back in ST_RUN
//  an empty line starts no drain; input stalls during the drain and while a finished
//  result still waits for out_ch.ready at drain end
//  rst is synchronous; it clears runs, counters and query_length (to 1), not query chars
module line_query_longest_common_run_unit import lqlcr_pkg::*; #(
  parameter int MAX_QUERY  = MAX_QUERY_DEF,
  parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  lqlcr_in_if.sink          in_ch,
  lqlcr_out_if.source       out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cell_ctrl_t       cell_ctrl;
  logic [RUN_W-1:0] run_link [0:MAX_QUERY];
  logic [RUN_W-1:0] max_link [0:MAX_QUERY];

  lqlcr_ctrl #(
    .MAX_QUERY  (MAX_QUERY),
    .LINE_LIMIT (LINE_LIMIT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .best_in   (max_link[MAX_QUERY]),
    .cell_ctrl (cell_ctrl)
  );

  // chain heads: no run before the first position, no max before the first cell
  assign run_link[0] = '0;
  assign max_link[0] = '0;

  // row of query cells
  for (genvar j = 0; j < MAX_QUERY; j++) begin : g_cell
    lqlcr_cell #(
      .CELL_IDX (j)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (cell_ctrl),
      .run_in  (run_link[j]),
      .max_in  (max_link[j]),
      .run_out (run_link[j+1]),
      .max_out (max_link[j+1])
    );
  end

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for line_query_longest_common_run_unit
// drives query loads and text bytes, predicts line results and compares them
// depends on lqlcr_pkg, lqlcr_if and the block's rtl
module tb;
  import lqlcr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one finished line as the block reports it
  typedef struct packed {
    logic [LINE_W-1:0]  line_number;
    logic [BYTES_W-1:0] byte_count;
    logic [RUN_W-1:0]   best_match;
    logic               too_long;
  } line_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_QLEN
  } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic              req_type;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
    bit                typed;
    line_result_t      want;
  } directed_row_t;

  localparam logic [APB_AW-1:0] QLEN_ADDR = {REG_QUERY_LENGTH, 2'b00};
  localparam int LONG_HOLD = 600;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  lqlcr_in_if  in_ch ();
  lqlcr_out_if out_ch ();

  line_query_longest_common_run_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [DATA_W-1:0]  q_chars [MAX_QUERY_DEF];
  logic [RUN_W-1:0]   run_len [MAX_QUERY_DEF];
  logic [RUN_W-1:0]   line_best;
  logic [BYTES_W-1:0] line_bytes;
  logic [LINE_W-1:0]  line_no;
  logic               overlong;
  logic [LEN_W-1:0]   q_len_cfg;

  line_result_t  pending_lines[$];
  directed_row_t directed_rows[$];

  int unsigned items_sent;
  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_armed;
  bit          hold_done;
  int unsigned hold_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run guard
  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [DATA_W-1:0] to_lower(input logic [DATA_W-1:0] c);
    if (c >= "A" && c <= "Z") begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic [DATA_W-1:0] flip_case(input logic [DATA_W-1:0] c);
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  function automatic void predictor_reset();
    foreach (run_len[j]) run_len[j] = '0;
    foreach (q_chars[j]) q_chars[j] = '0;
    line_best  = '0;
    line_bytes = '0;
    line_no    = 16'd1;
    overlong   = 1'b0;
    q_len_cfg  = QLEN_RESET;
  endfunction

  // advance the predicted block by one accepted transaction
  function automatic void line_match_step(input logic rt, input logic [IDX_W-1:0] idx,
                                          input logic [DATA_W-1:0] b,
                                          output bit has_res, output line_result_t res);
    int unsigned used;
    logic [DATA_W-1:0] t;
    logic [RUN_W-1:0] nxt;
    logic [RUN_W-1:0] prv;
    has_res = 1'b0;
    res = '0;
    if (rt == REQ_LOAD) begin
      q_chars[idx] = b;
      return;
    end
    // newline closes the line, empty lines only bump the counter
    if (b == NEWLINE) begin
      if (line_bytes != 0) begin
        res = '{line_no, line_bytes, line_best, overlong};
        has_res = 1'b1;
      end
      foreach (run_len[j]) run_len[j] = '0;
      line_best  = '0;
      line_bytes = '0;
      overlong   = 1'b0;
      if (line_no != LINE_CAP) line_no++;
      return;
    end
    if (line_bytes != BYTE_CAP) line_bytes++;
    if (line_bytes >= LINE_LIMIT_DEF) overlong = 1'b1;
    used = (q_len_cfg > MAX_QUERY_DEF) ? MAX_QUERY_DEF : q_len_cfg;
    t = to_lower(b);
    // top down so run_len[j-1] still holds the previous byte's value
    for (int j = MAX_QUERY_DEF - 1; j >= 0; j--) begin
      nxt = '0;
      if (j < used && b != 0 && to_lower(q_chars[j]) == t) begin
        prv = (j > 0) ? run_len[j-1] : '0;
        nxt = (prv != 8'd255) ? prv + 8'd1 : prv;
      end
      run_len[j] = nxt;
      if (nxt > line_best) line_best = nxt;
    end
  endfunction

  // offer one transaction, predict it once it is taken
  task automatic send_item(input logic rt, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] b, input bit typed,
                           input line_result_t typed_res);
    bit has_res;
    line_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= rt;
    in_ch.query_index <= idx;
    in_ch.byte_value  <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    line_match_step(rt, idx, b, has_res, res);
    if (typed) begin
      pending_lines.push_back(typed_res);
    end else if (has_res) begin
      pending_lines.push_back(res);
    end
    items_sent++;
  endtask

  task automatic send_text(input logic [DATA_W-1:0] b);
    send_item(REQ_TEXT, '0, b, 1'b0, '0);
  endtask

  // register write once the block has gone quiet
  task automatic set_query_length(input logic [LEN_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (MAX_QUERY_DEF + 8) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= QLEN_ADDR;
    pwdata  <= APB_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    q_len_cfg = v;
  endtask

  // one line: mostly runs copied from the query, some noise, loads now and then
  task automatic send_random_line(input int unsigned max_len, input bit no_empty);
    int unsigned used;
    int unsigned len;
    int unsigned pos;
    int unsigned pick;
    logic [DATA_W-1:0] c;
    used = (q_len_cfg > MAX_QUERY_DEF) ? MAX_QUERY_DEF : q_len_cfg;
    if (used == 0) used = 1;
    len = (!no_empty && $urandom_range(9) == 0) ? 0 : $urandom_range(1, max_len);
    pos = $urandom_range(used - 1);
    for (int unsigned k = 0; k < len; k++) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_item(REQ_LOAD, IDX_W'($urandom_range(127)), DATA_W'($urandom_range(255)),
                  1'b0, '0);
      end else begin
        if (pick < 75) begin
          if ($urandom_range(7) == 0) pos = $urandom_range(used - 1);
          c = q_chars[pos];
          pos = (pos + 1) % used;
          if ($urandom_range(1) == 1) c = flip_case(c);
        end else if (pick < 79) begin
          c = '0;
        end else begin
          c = DATA_W'($urandom_range(1, 255));
          if (c == NEWLINE) c = c + 8'd1;
        end
        send_text(c);
      end
    end
    send_text(NEWLINE);
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < count) send_random_line(12, 1'b0);
  endtask

  function automatic void add_item(input logic rt, input logic [IDX_W-1:0] idx,
                                   input logic [DATA_W-1:0] b, input bit typed,
                                   input line_result_t want);
    directed_row_t r;
    r.kind = ROW_ITEM;
    r.req_type = rt;
    r.idx = idx;
    r.value = b;
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_qlen(input logic [LEN_W-1:0] v);
    directed_rows.push_back('{ROW_QLEN, REQ_LOAD, '0, v, 1'b0, '0});
  endfunction

  // receiver: random ready, plus one long hold-off when armed
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    line_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_lines.size() == 0) begin
        $error("result with none pending: line_number %0d", out_ch.line_number);
        mismatch_count++;
      end else begin
        want = pending_lines.pop_front();
        if (out_ch.line_number !== want.line_number) begin
          $error("line_number expected %0d actual %0d", want.line_number,
                 out_ch.line_number);
          mismatch_count++;
        end
        if (out_ch.byte_count !== want.byte_count) begin
          $error("byte_count expected %0d actual %0d", want.byte_count, out_ch.byte_count);
          mismatch_count++;
        end
        if (out_ch.best_match !== want.best_match) begin
          $error("best_match expected %0d actual %0d", want.best_match, out_ch.best_match);
          mismatch_count++;
        end
        if (out_ch.too_long !== want.too_long) begin
          $error("too_long expected %0d actual %0d", want.too_long, out_ch.too_long);
          mismatch_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    logic [DATA_W-1:0] c;
    int unsigned lengths [2];
    items_sent     = 0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_armed     = 1'b0;
    hold_done      = 1'b0;
    hold_left      = 0;
    predictor_reset();
    rst               <= 1'b1;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_LOAD;
    in_ch.query_index <= '0;
    in_ch.byte_value  <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every query position so no unwritten entry is ever compared
    for (int i = 0; i < MAX_QUERY_DEF; i++) begin
      c = DATA_W'($urandom_range("a", "f"));
      if ($urandom_range(1) == 1) c = flip_case(c);
      send_item(REQ_LOAD, IDX_W'(i), c, 1'b0, '0);
    end

    // directed rows
    add_qlen(8'd4);
    add_item(REQ_LOAD, 7'd0, "a", 1'b0, '0);
    add_item(REQ_LOAD, 7'd1, "B", 1'b0, '0);
    add_item(REQ_LOAD, 7'd2, "c", 1'b0, '0);
    add_item(REQ_LOAD, 7'd3, 8'hFF, 1'b0, '0);
    add_item(REQ_LOAD, 7'd127, NEWLINE, 1'b0, '0);
    add_item(REQ_TEXT, 7'd0, "A", 1'b0, '0);
    add_item(REQ_TEXT, 7'd0, "b", 1'b0, '0);
    add_item(REQ_TEXT, 7'd0, "C", 1'b0, '0);
    add_item(REQ_TEXT, 7'd0, NEWLINE, 1'b1, '{16'd1, 10'd3, 8'd3, 1'b0});
    // empty line: no result, counter still moves
    add_item(REQ_TEXT, 7'd0, NEWLINE, 1'b0, '0);
    // zero byte breaks the run and never matches
    add_item(REQ_TEXT, 7'd0, 8'h00, 1'b0, '0);
    add_item(REQ_TEXT, 7'd0, 8'hFF, 1'b0, '0);
    add_item(REQ_TEXT, 7'd0, NEWLINE, 1'b1, '{16'd3, 10'd2, 8'd1, 1'b0});
    // no positions in use
    add_qlen(8'd0);
    add_item(REQ_TEXT, 7'd0, "a", 1'b0, '0);
    add_item(REQ_TEXT, 7'd0, NEWLINE, 1'b1, '{16'd4, 10'd1, 8'd0, 1'b0});
    // length above the array size, query rewritten in mid line
    add_qlen(8'd255);
    add_item(REQ_TEXT, 7'd0, "z", 1'b0, '0);
    add_item(REQ_TEXT, 7'd0, "a", 1'b0, '0);
    add_item(REQ_TEXT, 7'd0, "B", 1'b0, '0);
    add_item(REQ_LOAD, 7'd1, "x", 1'b0, '0);
    add_item(REQ_TEXT, 7'd0, "c", 1'b0, '0);
    add_item(REQ_TEXT, 7'd0, NEWLINE, 1'b0, '0);
    add_qlen(8'd128);
    add_item(REQ_TEXT, 7'd0, "a", 1'b0, '0);
    add_item(REQ_TEXT, 7'd0, "x", 1'b0, '0);
    add_item(REQ_TEXT, 7'd0, NEWLINE, 1'b0, '0);

    send_idle_pct = 35;
    recv_idle_pct = 72;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_QLEN) begin
        set_query_length(directed_rows[i].value);
      end else begin
        send_item(directed_rows[i].req_type, directed_rows[i].idx, directed_rows[i].value,
                  directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // random lines, sender idles less than the receiver
    set_query_length(LEN_W'($urandom_range(2, 127)));
    random_phase(100);

    // receiver idles less than the sender, single position in use
    set_query_length(8'd1);
    send_idle_pct = 72;
    recv_idle_pct = 35;
    random_phase(100);

    // no idling, one long receiver hold-off so the block backs up
    set_query_length(8'd128);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_armed = 1'b1;
    random_phase(100);

    // lines at the length limit and past the byte count cap
    set_query_length(LEN_W'($urandom_range(1, 128)));
    lengths = '{1000, 1030};
    foreach (lengths[i]) begin
      for (int unsigned k = 0; k < lengths[i]; k++) begin
        c = q_chars[k % MAX_QUERY_DEF];
        if (c == NEWLINE || $urandom_range(15) == 0) c = "q";
        send_text(c);
      end
      send_text(NEWLINE);
    end

    // a few lines with the length register above the array size
    set_query_length(8'd255);
    for (int k = 0; k < 4; k++) send_random_line(12, 1'b1);

    // trailing bytes without a newline give nothing
    send_text("a");
    send_text("b");
    in_ch.valid <= 1'b0;

    while (pending_lines.size() != 0) @(posedge clk);
    repeat (MAX_QUERY_DEF + 16) @(posedge clk);
    if (mismatch_count == 0 && pending_lines.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
